/* hdl/mf8n_pkg.sv */
package mf8n_pkg;
  localparam int MaxWidth = 1024;
  localparam int AddrW = $clog2(MaxWidth);
  localparam int PixW = 24;
  localparam int ResW = 51;
  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode = 2'd2;

  typedef logic [PixW-1:0] pix_t;

  // fifth smallest of eight: count of elements below, with index tie break
  function automatic logic [7:0] fifth8(input logic [7:0] v [8]);
    logic [7:0] res;
    logic [3:0] rank;
    res = 8'd0;
    for (int i = 0; i < 8; i++) begin
      rank = 4'd0;
      for (int j = 0; j < 8; j++) begin
        if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) rank = rank + 4'd1;
      end
      if (rank == 4'd4) res = v[i];
    end
    return res;
  endfunction
endpackage

/* hdl/median_filter_8_neighbour_core.sv */
// inputs pass stages 1 and 2 to the queue; results leave one per cycle while m_tready is high
// throughput: one pixel per cycle with m_tready high while each input causes at most one result;
//   last column and bottom-row inputs can cause up to four results and stall the input
// the line buffers are two 1024x24 synchronous rams with a registered read
// reset clears the counters and the pipeline; the rams and window are not cleared
module median_filter_8_neighbour_core
  import mf8n_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // sample0, sample1, sample2
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_row, out_col, value0, value1, value2, then pad
  output logic [0:0]  m_tuser,   // frame_done
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic        color_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024;
      image_height <= 16'd1024;
      color_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegWidth: image_width <= cfg_wdata[10:0];
        RegHeight: image_height <= cfg_wdata;
        RegMode: color_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [10:0] w_eff;
  logic [15:0] h_eff;
  always_comb begin
    w_eff = image_width;
    if (w_eff == 11'd0) w_eff = 11'd1;
    if (w_eff > 11'(MaxWidth)) w_eff = 11'(MaxWidth);
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
  end

  // stage 0 counters
  logic [15:0] row_count;
  logic [10:0] col_count;
  logic        s_fire;
  logic        adv;
  logic        last_col, last_row;
  logic [AddrW-1:0] ci;
  assign last_col = ({1'b0, col_count} + 12'd1) >= {1'b0, w_eff};
  assign last_row = ({1'b0, row_count} + 17'd1) >= {1'b0, h_eff};
  assign ci = (col_count >= 11'(MaxWidth)) ? AddrW'(MaxWidth - 1) : col_count[AddrW-1:0];
  assign s_tready = adv;
  assign s_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 16'd0;
      col_count <= 11'd0;
    end else if (s_fire) begin
      if (last_col) begin
        col_count <= 11'd0;
        row_count <= last_row ? 16'd0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + 11'd1;
      end
    end
  end

  // line rams
  pix_t ram_a [MaxWidth];
  pix_t ram_b [MaxWidth];
  pix_t rd_a, rd_b;

  // stage 1: ram read in flight
  logic        v1;
  logic [AddrW-1:0] a1;
  pix_t        px1;
  logic [15:0] r1;
  logic [10:0] c1;
  logic        lc1, lr1;

  // forwarding: same address written by stage 1 in this cycle
  logic        fwd;
  pix_t        fa;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_a <= ram_a[ci];
      rd_b <= ram_b[ci];
    end
    if (adv && v1) begin
      ram_a[a1] <= px1;
      ram_b[a1] <= fa;
    end
  end

  // effective stage 1 read data (with bypass from a previous write to same entry)
  pix_t above1, two1;
  logic        byp_v;
  pix_t        byp_a, byp_b;
  always_comb begin
    above1 = byp_v ? byp_a : rd_a;
    two1 = byp_v ? byp_b : rd_b;
    fa = above1;
  end
  assign fwd = v1 && (a1 == ci);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_fire;
    if (adv) begin
      a1 <= ci;
      px1 <= s_tdata;
      r1 <= row_count;
      c1 <= col_count;
      lc1 <= last_col;
      lr1 <= last_row;
      byp_v <= fwd;
      byp_a <= px1;
      byp_b <= above1;
    end
  end

  // stage 2: window and medians
  pix_t win [3][3];
  logic        v2;
  logic [15:0] r2;
  logic [10:0] c2;
  logic        lc2, lr2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv && v1) begin
      for (int y = 0; y < 3; y++) begin
        win[y][0] <= win[y][1];
        win[y][1] <= win[y][2];
      end
      win[0][2] <= two1;
      win[1][2] <= above1;
      win[2][2] <= px1;
      r2 <= r1;
      c2 <= c1;
      lc2 <= lc1;
      lr2 <= lr1;
    end
  end

  logic [7:0] med [3];
  always_comb begin
    logic [7:0] v [8];
    for (int k = 0; k < 3; k++) begin
      v[0] = win[0][0][8*k +: 8];
      v[1] = win[0][1][8*k +: 8];
      v[2] = win[0][2][8*k +: 8];
      v[3] = win[1][0][8*k +: 8];
      v[4] = win[1][2][8*k +: 8];
      v[5] = win[2][0][8*k +: 8];
      v[6] = win[2][1][8*k +: 8];
      v[7] = win[2][2][8*k +: 8];
      med[k] = fifth8(v);
    end
  end

  // build up to four results in stage 2
  logic [ResW-1:0] res [4];
  logic [3:0]      rv;
  always_comb begin
    logic interior;
    logic [15:0] pr;
    logic [10:0] pc;
    pix_t p1, pm;
    pr = r2 - 16'd1;
    pc = c2 - 11'd1;
    interior = (pr >= 16'd1) && (({1'b0, pr} + 17'd1) < {1'b0, h_eff}) &&
               (pc >= 11'd1) && (({1'b0, pc} + 12'd1) < {1'b0, w_eff});
    pm = {med[2], med[1], med[0]};
    p1 = interior ? pm : win[1][1];
    if (!color_mode) begin
      p1[23:8] = 16'd0;
    end
    rv[0] = (r2 >= 16'd1) && (c2 >= 11'd1);
    rv[1] = (r2 >= 16'd1) && lc2;
    rv[2] = lr2 && (c2 >= 11'd1);
    rv[3] = lr2 && lc2;
    res[0] = {1'b0, p1, c2[9:0] - 10'd1, pr};
    res[1] = {1'b0, color_mode ? win[1][2] : {16'd0, win[1][2][7:0]}, c2[9:0], pr};
    res[2] = {1'b0, color_mode ? win[2][1] : {16'd0, win[2][1][7:0]}, c2[9:0] - 10'd1, r2};
    res[3] = {1'b1, color_mode ? win[2][2] : {16'd0, win[2][2][7:0]}, c2[9:0], r2};
  end

  // output queue: holds results of one input, emitted one per cycle while m_tready is high
  logic [ResW-1:0] q [4];
  logic [3:0]      qv;
  logic            q_busy;
  assign q_busy = |qv;
  // advance when queue empties this cycle or is already empty
  logic [1:0] head;
  logic       take;
  logic [3:0] qv_after;
  always_comb begin
    head = 2'd0;
    for (int i = 3; i >= 0; i--) if (qv[i]) head = 2'(i);
    take = q_busy && m_tready;
    qv_after = qv;
    if (take) qv_after[head] = 1'b0;
  end
  assign adv = (qv_after == 4'd0);
  assign m_tvalid = q_busy;
  always_comb begin
    logic [ResW-1:0] h;
    h = q[head];
    m_tdata = {6'd0, h[49:0]};
    m_tuser = h[50];
    m_tlast = 1'b1;
    for (int i = 0; i < 4; i++) if (qv[i] && (2'(i) > head)) m_tlast = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) qv <= 4'd0;
    else if (adv) qv <= v2 ? rv : 4'd0;
    else qv <= qv_after;
    if (adv) begin
      for (int i = 0; i < 4; i++) q[i] <= res[i];
    end
  end
endmodule

/* test/tb_top.sv */
module tb_top
  import mf8n_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 12;

  typedef struct packed {
    logic [15:0] row;
    logic [9:0]  col;
    logic [7:0]  v0;
    logic [7:0]  v1;
    logic [7:0]  v2;
    logic        last;
    logic        frame_done;
  } filt_out_t;

  typedef struct {
    pix_t      px;
    int        cfg_before;  // 0 none, 1 degenerate 1x1 color, 2 gray
    bit        has_exp;
    filt_out_t exp_out;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // sample0, sample1, sample2
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;    // out_row, out_col, value0, value1, value2, then pad
  logic [0:0]  m_tuser;    // frame_done
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  median_filter_8_neighbour_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  pix_t        line_prev [MaxWidth];
  pix_t        line_prev2 [MaxWidth];
  pix_t        win [3][3];
  logic [15:0] pos_row;
  logic [9:0]  pos_col;
  logic [10:0] cfg_width;
  logic [15:0] cfg_height;
  logic        cfg_color;

  filt_out_t   pending_px [$];
  int          idle_mode;
  int          errors;
  int          pixels_in;
  int          pixels_out;
  int          frames_done;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] median_of_ring(input int k);
    logic [7:0] v [8];
    logic [7:0] t;
    int n;
    int j;
    n = 0;
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        if (!(y == 1 && x == 1)) begin
          v[n] = win[y][x][8*k +: 8];
          n++;
        end
    for (int i = 1; i < 8; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    return v[4];
  endfunction

  function automatic filt_out_t make_out(input int row, input int col, input pix_t p,
                                         input bit med);
    filt_out_t o;
    o.row = row[15:0];
    o.col = col[9:0];
    o.v0 = med ? median_of_ring(0) : p[7:0];
    o.v1 = cfg_color ? (med ? median_of_ring(1) : p[15:8]) : 8'd0;
    o.v2 = cfg_color ? (med ? median_of_ring(2) : p[23:16]) : 8'd0;
    o.last = 1'b0;
    o.frame_done = 1'b0;
    return o;
  endfunction

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MaxWidth) return MaxWidth;
    return cfg_width;
  endfunction

  function automatic int eff_height();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  function automatic void predict_pixel(input pix_t p);
    filt_out_t res [4];
    int w;
    int h;
    int r;
    int c;
    int n;
    bit lc;
    bit lr;
    bit inner;
    w = eff_width();
    h = eff_height();
    r = pos_row;
    c = pos_col;
    lc = (c + 1 >= w);
    lr = (r + 1 >= h);
    n = 0;
    for (int y = 0; y < 3; y++) begin
      win[y][0] = win[y][1];
      win[y][1] = win[y][2];
    end
    win[0][2] = line_prev2[c];
    win[1][2] = line_prev[c];
    win[2][2] = p;
    line_prev2[c] = line_prev[c];
    line_prev[c] = p;
    if (r >= 1) begin
      if (c >= 1) begin
        inner = (r - 1 >= 1) && (r < h) && (c - 1 >= 1) && (c < w);
        res[n] = make_out(r - 1, c - 1, win[1][1], inner);
        n++;
      end
      if (lc) begin
        res[n] = make_out(r - 1, c, win[1][2], 1'b0);
        n++;
      end
    end
    if (lr) begin
      if (c >= 1) begin
        res[n] = make_out(r, c - 1, win[2][1], 1'b0);
        n++;
      end
      if (lc) begin
        res[n] = make_out(r, c, win[2][2], 1'b0);
        res[n].frame_done = 1'b1;
        n++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_px = {pending_px, res[i]};
    if (lc) begin
      pos_col = '0;
      pos_row = lr ? 16'd0 : pos_row + 16'd1;
    end else begin
      pos_col = pos_col + 10'd1;
    end
  endfunction

  function automatic bit sender_idle();
    if (idle_mode == 1) return $urandom_range(0, 99) < 75;
    if (idle_mode == 3) return $urandom_range(0, 99) < 20;
    return 1'b0;
  endfunction

  function automatic bit receiver_stall();
    if (idle_mode == 2) return $urandom_range(0, 99) < 75;
    if (idle_mode == 3) return $urandom_range(0, 99) < 20;
    return 1'b0;
  endfunction

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !receiver_stall();
  end

  // result checker
  always @(posedge clk) begin
    filt_out_t got;
    filt_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.row = m_tdata[15:0];
      got.col = m_tdata[25:16];
      got.v0 = m_tdata[33:26];
      got.v1 = m_tdata[41:34];
      got.v2 = m_tdata[49:42];
      got.last = m_tlast;
      got.frame_done = m_tuser[0];
      pixels_out++;
      if (got.frame_done) frames_done++;
      if (pending_px.size() == 0) begin
        $error("unexpected result transfer row %0d col %0d", got.row, got.col);
        errors++;
      end else begin
        want = pending_px.pop_front();
        if (got.row !== want.row) begin
          $error("out_row expected %0d got %0d", want.row, got.row); errors++;
        end
        if (got.col !== want.col) begin
          $error("out_col expected %0d got %0d", want.col, got.col); errors++;
        end
        if (got.v0 !== want.v0) begin
          $error("value0 expected %0d got %0d", want.v0, got.v0); errors++;
        end
        if (got.v1 !== want.v1) begin
          $error("value1 expected %0d got %0d", want.v1, got.v1); errors++;
        end
        if (got.v2 !== want.v2) begin
          $error("value2 expected %0d got %0d", want.v2, got.v2); errors++;
        end
        if (got.last !== want.last) begin
          $error("last expected %0d got %0d", want.last, got.last); errors++;
        end
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done expected %0d got %0d", want.frame_done, got.frame_done);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_pixel(input pix_t p);
    @(negedge clk);
    while (sender_idle()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(p);
    pixels_in++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // block must be drained before calling
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegWidth: cfg_width = val[10:0];
      RegHeight: cfg_height = val;
      RegMode: cfg_color = val[0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input int w, input int h, input bit color);
    wait_drained();
    write_reg(RegWidth, w[15:0]);
    write_reg(RegHeight, h[15:0]);
    write_reg(RegMode, {15'd0, color});
  endtask

  function automatic pix_t rand_pixel();
    pix_t p;
    case ($urandom_range(0, 3))
      0: for (int k = 0; k < 3; k++) p[8*k +: 8] = 8'($urandom_range(0, 3) * 85);
      1: for (int k = 0; k < 3; k++) p[8*k +: 8] = 8'(120 + $urandom_range(0, 4));
      default: p = 24'($urandom);
    endcase
    return p;
  endfunction

  task automatic send_frame();
    int n;
    n = eff_width() * eff_height();
    for (int i = 0; i < n; i++) push_pixel(rand_pixel());
  endtask

  dir_row_t dir_tab [$];

  task automatic build_table();
    dir_row_t d;
    pix_t ring [9];
    ring = '{24'h00ff10, 24'hffffff, 24'h000000, 24'h7f807f, 24'h55aa01,
             24'hff00ff, 24'h010203, 24'h808080, 24'hfe01fe};
    for (int i = 0; i < 9; i++) begin
      d.px = ring[i];
      d.cfg_before = 0;
      d.has_exp = 1'b0;
      d.exp_out = '0;
      dir_tab = {dir_tab, d};
    end
    // width and height of zero act as one: a single pixel copied through
    d.px = 24'hc35a0f;
    d.cfg_before = 1;
    d.has_exp = 1'b1;
    d.exp_out = '{16'd0, 10'd0, 8'h0f, 8'h5a, 8'hc3, 1'b1, 1'b1};
    dir_tab = {dir_tab, d};
    // gray mode zeroes channels 1 and 2
    d.px = 24'hffffff;
    d.cfg_before = 2;
    d.exp_out = '{16'd0, 10'd0, 8'hff, 8'h00, 8'h00, 1'b1, 1'b1};
    dir_tab = {dir_tab, d};
    d.px = 24'h123400;
    d.cfg_before = 0;
    d.exp_out = '{16'd0, 10'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1};
    dir_tab = {dir_tab, d};
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegWidth;
    cfg_wdata = '0;
    errors = 0;
    pixels_in = 0;
    pixels_out = 0;
    frames_done = 0;
    quiet_cycles = 0;
    idle_mode = 0;
    pos_row = '0;
    pos_col = '0;
    cfg_width = 11'd1024;
    cfg_height = 16'd1024;
    cfg_color = 1'b0;
    for (int i = 0; i < MaxWidth; i++) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) win[y][x] = '0;
    build_table();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one 3x3 color frame, then degenerate single-pixel frames
    set_frame(3, 3, 1'b1);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_before == 1) set_frame(0, 0, 1'b1);
      if (dir_tab[i].cfg_before == 2) begin
        wait_drained();
        write_reg(RegMode, 16'd0);
      end
      push_pixel(dir_tab[i].px);
      if (dir_tab[i].has_exp) begin
        pending_px[pending_px.size() - 1] = dir_tab[i].exp_out;
      end
    end

    // random frames under each idling pattern
    for (int m = 0; m < 4; m++) begin
      int start;
      idle_mode = m;
      start = pixels_in;
      while (pixels_in - start < 40) begin
        case ($urandom_range(0, 5))
          0: set_frame(3, 3, $urandom_range(0, 1));
          1: set_frame(1, $urandom_range(1, 6), $urandom_range(0, 1));
          2: set_frame($urandom_range(1, 8), 1, $urandom_range(0, 1));
          default: set_frame($urandom_range(2, 9), $urandom_range(2, 6), $urandom_range(0, 1));
        endcase
        send_frame();
      end
    end

    // extremes of the registers: widest rows cut short by a width write
    idle_mode = 3;
    set_frame(1024, 2, 1'b0);
    for (int i = 0; i < 6; i++) push_pixel(rand_pixel());
    wait_drained();
    write_reg(RegWidth, 16'd3);
    for (int i = 0; i < 3; i++) push_pixel(rand_pixel());
    set_frame(2047, 1, 1'b1);
    for (int i = 0; i < 4; i++) push_pixel(rand_pixel());
    wait_drained();
    write_reg(RegWidth, 16'd5);
    push_pixel(rand_pixel());
    // height shrunk mid-frame: counters land past the end
    set_frame(4, 5, 1'b1);
    for (int i = 0; i < 12; i++) push_pixel(rand_pixel());
    wait_drained();
    write_reg(RegHeight, 16'd2);
    for (int i = 0; i < 4; i++) push_pixel(rand_pixel());
    set_frame(1, 65535, 1'b0);
    for (int i = 0; i < 3; i++) push_pixel(rand_pixel());
    wait_drained();
    write_reg(RegHeight, 16'd1);
    push_pixel(rand_pixel());

    wait_drained();
    $display("%0d pixels in, %0d pixels out over %0d frames", pixels_in, pixels_out,
             frames_done);
    $display("gray and color, widths 0 to 2047, heights 0 to 65535, four idle patterns");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* median_filter_8_neighbour_core.f */
hdl/mf8n_pkg.sv
hdl/median_filter_8_neighbour_core.sv
test/tb_top.sv
